/* rtl/cstb_pkg.sv */
// ----------------------------------------------------------------------------
// Timer bank package
// Shared constants, codes and types of the cascaded software timer bank.
// ----------------------------------------------------------------------------
package cstb_pkg;

   localparam int NUM_CENTI_TIMERS = 8;
   localparam int NUM_DECI_TIMERS  = 8;
   localparam int NUM_SEC_TIMERS   = 8;
   localparam int NUM_MIN_TIMERS   = 8;
   localparam int NUM_HOUR_TIMERS  = 8;

   localparam int CENTI_IW = (NUM_CENTI_TIMERS > 1) ? $clog2(NUM_CENTI_TIMERS) : 1;
   localparam int DECI_IW  = (NUM_DECI_TIMERS > 1)  ? $clog2(NUM_DECI_TIMERS)  : 1;
   localparam int SEC_IW   = (NUM_SEC_TIMERS > 1)   ? $clog2(NUM_SEC_TIMERS)   : 1;
   localparam int MIN_IW   = (NUM_MIN_TIMERS > 1)   ? $clog2(NUM_MIN_TIMERS)   : 1;
   localparam int HOUR_IW  = (NUM_HOUR_TIMERS > 1)  ? $clog2(NUM_HOUR_TIMERS)  : 1;

   localparam int MAX_A = (NUM_CENTI_TIMERS > NUM_DECI_TIMERS) ?
                          NUM_CENTI_TIMERS : NUM_DECI_TIMERS;
   localparam int MAX_B = (NUM_SEC_TIMERS > NUM_MIN_TIMERS) ?
                          NUM_SEC_TIMERS : NUM_MIN_TIMERS;
   localparam int MAX_C = (MAX_A > MAX_B) ? MAX_A : MAX_B;
   localparam int MAX_TIMERS = (MAX_C > NUM_HOUR_TIMERS) ? MAX_C : NUM_HOUR_TIMERS;
   localparam int WALK_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

   localparam logic [7:0] CNT_MAX    = 8'd255;
   localparam logic [3:0] TEN_WRAP   = 4'd9;
   localparam logic [5:0] SIXTY_WRAP = 6'd59;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [2:0] BANK_CENTI = 3'd0;
   localparam logic [2:0] BANK_DECI  = 3'd1;
   localparam logic [2:0] BANK_SEC   = 3'd2;
   localparam logic [2:0] BANK_MIN   = 3'd3;
   localparam logic [2:0] BANK_HOUR  = 3'd4;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_TICK,
      CMD_START,
      CMD_READ,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   bank;
      logic [2:0]   index;
   } cmd_type;

   typedef struct packed {
      logic [7:0] count_value;
      logic [5:0] sub_count;
      logic       index_error;
   } result_type;

   typedef enum logic [0:0] {
      BK_IDLE,
      BK_WALK
   } back_state_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] c);
      return (c == CNT_MAX) ? c : c + 8'd1;
   endfunction

endpackage

/* rtl/cstb_front.sv */
// ----------------------------------------------------------------------------
// Timer bank front end
// Accepts requests, checks the timer selection and queues decoded commands.
// ----------------------------------------------------------------------------
module cstb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_opcode,
   input  logic [2:0]       req_timer_class,
   input  logic [2:0]       req_timer_index,
   output logic             cmd_valid,
   output cstb_pkg::cmd_type cmd_head,
   input  logic             cmd_pop
);

   cstb_pkg::cmd_type cmd_dec;
   logic              sel_ok;
   logic              push_take;
   logic              pop_take;

   cstb_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      unique case (req_timer_class)
         cstb_pkg::BANK_CENTI: sel_ok = int'(req_timer_index) < cstb_pkg::NUM_CENTI_TIMERS;
         cstb_pkg::BANK_DECI:  sel_ok = int'(req_timer_index) < cstb_pkg::NUM_DECI_TIMERS;
         cstb_pkg::BANK_SEC:   sel_ok = int'(req_timer_index) < cstb_pkg::NUM_SEC_TIMERS;
         cstb_pkg::BANK_MIN:   sel_ok = int'(req_timer_index) < cstb_pkg::NUM_MIN_TIMERS;
         cstb_pkg::BANK_HOUR:  sel_ok = int'(req_timer_index) < cstb_pkg::NUM_HOUR_TIMERS;
         default:              sel_ok = 1'b0;
      endcase
   end

   always_comb begin
      cmd_dec.bank  = req_timer_class;
      cmd_dec.index = req_timer_index;
      unique case (req_opcode)
         cstb_pkg::OP_TICK:  cmd_dec.kind = cstb_pkg::CMD_TICK;
         cstb_pkg::OP_START: cmd_dec.kind = sel_ok ? cstb_pkg::CMD_START : cstb_pkg::CMD_ERROR;
         cstb_pkg::OP_READ:  cmd_dec.kind = sel_ok ? cstb_pkg::CMD_READ : cstb_pkg::CMD_ERROR;
         default:            cmd_dec.kind = cstb_pkg::CMD_NOP;
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_head  = q_ff[rd_ptr_ff];
   assign push_take = req_push && !req_full;
   assign pop_take  = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push_take ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_take} - {1'b0, pop_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_take) begin
         q_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

endmodule

/* rtl/cstb_back.sv */
// ----------------------------------------------------------------------------
// Timer bank back end
// Executes queued commands on the timer storage and queues the results.
// ----------------------------------------------------------------------------
module cstb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cstb_pkg::cmd_type cmd_head,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_count_value,
   output logic [5:0]        rsp_sub_count,
   output logic              rsp_index_error
);

   cstb_pkg::back_state_type state_ff, state_in;
   logic [cstb_pkg::WALK_W-1:0] walk_ff, walk_in;
   logic walk_last;
   logic walk_on;
   logic cmd_take;
   logic tick_take;
   logic start_take;

   logic [3:0] shared_centi_ff, shared_centi_in;
   logic [3:0] shared_deci_ff, shared_deci_in;
   logic [5:0] shared_sec_ff, shared_sec_in;
   logic       step_sec_ff, step_sec_in;
   logic       step_min_ff, step_min_in;
   logic       step_hour_ff, step_hour_in;
   logic [3:0] centi_inc;
   logic [3:0] deci_inc;
   logic [5:0] sec_inc;
   logic       wrap_c, wrap_d, wrap_s;

   logic [7:0] centi_cnt_ff [cstb_pkg::NUM_CENTI_TIMERS];
   logic [7:0] deci_cnt_ff  [cstb_pkg::NUM_DECI_TIMERS];
   logic [3:0] deci_sub_ff  [cstb_pkg::NUM_DECI_TIMERS];
   logic [7:0] sec_cnt_ff   [cstb_pkg::NUM_SEC_TIMERS];
   logic [3:0] sec_sub_ff   [cstb_pkg::NUM_SEC_TIMERS];
   logic [7:0] min_cnt_ff   [cstb_pkg::NUM_MIN_TIMERS];
   logic [5:0] min_sub_ff   [cstb_pkg::NUM_MIN_TIMERS];
   logic [7:0] hour_cnt_ff  [cstb_pkg::NUM_HOUR_TIMERS];
   logic [5:0] hour_sub_ff  [cstb_pkg::NUM_HOUR_TIMERS];

   logic [cstb_pkg::CENTI_IW-1:0] centi_addr;
   logic [cstb_pkg::DECI_IW-1:0]  deci_addr;
   logic [cstb_pkg::SEC_IW-1:0]   sec_addr;
   logic [cstb_pkg::MIN_IW-1:0]   min_addr;
   logic [cstb_pkg::HOUR_IW-1:0]  hour_addr;

   logic [7:0] centi_cnt_rd, deci_cnt_rd, sec_cnt_rd, min_cnt_rd, hour_cnt_rd;
   logic [3:0] deci_sub_rd, sec_sub_rd;
   logic [5:0] min_sub_rd, hour_sub_rd;

   logic       centi_we, deci_we, sec_we, min_we, hour_we;
   logic [7:0] centi_cnt_in, deci_cnt_in, sec_cnt_in, min_cnt_in, hour_cnt_in;
   logic [3:0] deci_sub_in, sec_sub_in;
   logic [5:0] min_sub_in, hour_sub_in;

   cstb_pkg::result_type res_new;
   cstb_pkg::result_type rq_ff [2];
   logic       rq_wr_ff, rq_wr_in;
   logic       rq_rd_ff, rq_rd_in;
   logic [1:0] rq_count_ff, rq_count_in;
   logic       rq_full;
   logic       rq_pop_take;

   assign rq_full     = (rq_count_ff == 2'd2);
   assign walk_last   = (walk_ff == cstb_pkg::WALK_W'(cstb_pkg::MAX_TIMERS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cstb_pkg::BK_IDLE: begin
            if (cmd_valid && !rq_full && cmd_head.kind == cstb_pkg::CMD_TICK) begin
               state_in = cstb_pkg::BK_WALK;
            end
         end
         cstb_pkg::BK_WALK: begin
            if (walk_last) begin
               state_in = cstb_pkg::BK_IDLE;
            end
         end
         default: state_in = cstb_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      walk_on  = (state_ff == cstb_pkg::BK_WALK);
      cmd_take = (state_ff == cstb_pkg::BK_IDLE) && cmd_valid && !rq_full;
      cmd_pop  = cmd_take;
      tick_take  = cmd_take && cmd_head.kind == cstb_pkg::CMD_TICK;
      start_take = cmd_take && cmd_head.kind == cstb_pkg::CMD_START;
      walk_in  = walk_on ? walk_ff + 1'b1 : '0;
   end

   always_comb begin
      centi_inc = shared_centi_ff + 4'd1;
      wrap_c    = centi_inc > cstb_pkg::TEN_WRAP;
      deci_inc  = shared_deci_ff + 4'd1;
      wrap_d    = deci_inc > cstb_pkg::TEN_WRAP;
      sec_inc   = shared_sec_ff + 6'd1;
      wrap_s    = sec_inc > cstb_pkg::SIXTY_WRAP;
      shared_centi_in = shared_centi_ff;
      shared_deci_in  = shared_deci_ff;
      shared_sec_in   = shared_sec_ff;
      step_sec_in     = step_sec_ff;
      step_min_in     = step_min_ff;
      step_hour_in    = step_hour_ff;
      if (tick_take) begin
         shared_centi_in = wrap_c ? 4'd0 : centi_inc;
         step_sec_in     = wrap_c;
         step_min_in     = wrap_c && wrap_d;
         step_hour_in    = wrap_c && wrap_d && wrap_s;
         if (wrap_c) begin
            shared_deci_in = wrap_d ? 4'd0 : deci_inc;
            if (wrap_d) begin
               shared_sec_in = wrap_s ? 6'd0 : sec_inc;
            end
         end
      end
   end

   always_comb begin
      centi_addr = walk_on ? cstb_pkg::CENTI_IW'(walk_ff) : cstb_pkg::CENTI_IW'(cmd_head.index);
      deci_addr  = walk_on ? cstb_pkg::DECI_IW'(walk_ff)  : cstb_pkg::DECI_IW'(cmd_head.index);
      sec_addr   = walk_on ? cstb_pkg::SEC_IW'(walk_ff)   : cstb_pkg::SEC_IW'(cmd_head.index);
      min_addr   = walk_on ? cstb_pkg::MIN_IW'(walk_ff)   : cstb_pkg::MIN_IW'(cmd_head.index);
      hour_addr  = walk_on ? cstb_pkg::HOUR_IW'(walk_ff)  : cstb_pkg::HOUR_IW'(cmd_head.index);
      centi_cnt_rd = centi_cnt_ff[centi_addr];
      deci_cnt_rd  = deci_cnt_ff[deci_addr];
      deci_sub_rd  = deci_sub_ff[deci_addr];
      sec_cnt_rd   = sec_cnt_ff[sec_addr];
      sec_sub_rd   = sec_sub_ff[sec_addr];
      min_cnt_rd   = min_cnt_ff[min_addr];
      min_sub_rd   = min_sub_ff[min_addr];
      hour_cnt_rd  = hour_cnt_ff[hour_addr];
      hour_sub_rd  = hour_sub_ff[hour_addr];
   end

   always_comb begin
      centi_cnt_in = 8'd0;
      deci_cnt_in  = 8'd0;
      deci_sub_in  = 4'd0;
      sec_cnt_in   = 8'd0;
      sec_sub_in   = 4'd0;
      min_cnt_in   = 8'd0;
      min_sub_in   = 6'd0;
      hour_cnt_in  = 8'd0;
      hour_sub_in  = 6'd0;
      if (walk_on) begin
         centi_we = int'(walk_ff) < cstb_pkg::NUM_CENTI_TIMERS;
         deci_we  = int'(walk_ff) < cstb_pkg::NUM_DECI_TIMERS;
         sec_we   = step_sec_ff && int'(walk_ff) < cstb_pkg::NUM_SEC_TIMERS;
         min_we   = step_min_ff && int'(walk_ff) < cstb_pkg::NUM_MIN_TIMERS;
         hour_we  = step_hour_ff && int'(walk_ff) < cstb_pkg::NUM_HOUR_TIMERS;
         centi_cnt_in = cstb_pkg::sat_inc(centi_cnt_rd);
         deci_sub_in  = (deci_sub_rd >= cstb_pkg::TEN_WRAP) ? 4'd0 : deci_sub_rd + 4'd1;
         deci_cnt_in  = (deci_sub_rd >= cstb_pkg::TEN_WRAP) ?
                        cstb_pkg::sat_inc(deci_cnt_rd) : deci_cnt_rd;
         sec_sub_in   = (sec_sub_rd >= cstb_pkg::TEN_WRAP) ? 4'd0 : sec_sub_rd + 4'd1;
         sec_cnt_in   = (sec_sub_rd >= cstb_pkg::TEN_WRAP) ?
                        cstb_pkg::sat_inc(sec_cnt_rd) : sec_cnt_rd;
         min_sub_in   = (min_sub_rd >= cstb_pkg::SIXTY_WRAP) ? 6'd0 : min_sub_rd + 6'd1;
         min_cnt_in   = (min_sub_rd >= cstb_pkg::SIXTY_WRAP) ?
                        cstb_pkg::sat_inc(min_cnt_rd) : min_cnt_rd;
         hour_sub_in  = (hour_sub_rd >= cstb_pkg::SIXTY_WRAP) ? 6'd0 : hour_sub_rd + 6'd1;
         hour_cnt_in  = (hour_sub_rd >= cstb_pkg::SIXTY_WRAP) ?
                        cstb_pkg::sat_inc(hour_cnt_rd) : hour_cnt_rd;
      end else begin
         centi_we = start_take && cmd_head.bank == cstb_pkg::BANK_CENTI;
         deci_we  = start_take && cmd_head.bank == cstb_pkg::BANK_DECI;
         sec_we   = start_take && cmd_head.bank == cstb_pkg::BANK_SEC;
         min_we   = start_take && cmd_head.bank == cstb_pkg::BANK_MIN;
         hour_we  = start_take && cmd_head.bank == cstb_pkg::BANK_HOUR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cstb_pkg::NUM_CENTI_TIMERS; i++) begin
            centi_cnt_ff[i] <= 8'd0;
         end
         for (int i = 0; i < cstb_pkg::NUM_DECI_TIMERS; i++) begin
            deci_cnt_ff[i] <= 8'd0;
            deci_sub_ff[i] <= 4'd0;
         end
         for (int i = 0; i < cstb_pkg::NUM_SEC_TIMERS; i++) begin
            sec_cnt_ff[i] <= 8'd0;
            sec_sub_ff[i] <= 4'd0;
         end
         for (int i = 0; i < cstb_pkg::NUM_MIN_TIMERS; i++) begin
            min_cnt_ff[i] <= 8'd0;
            min_sub_ff[i] <= 6'd0;
         end
         for (int i = 0; i < cstb_pkg::NUM_HOUR_TIMERS; i++) begin
            hour_cnt_ff[i] <= 8'd0;
            hour_sub_ff[i] <= 6'd0;
         end
      end else begin
         if (centi_we) begin
            centi_cnt_ff[centi_addr] <= centi_cnt_in;
         end
         if (deci_we) begin
            deci_cnt_ff[deci_addr] <= deci_cnt_in;
            deci_sub_ff[deci_addr] <= deci_sub_in;
         end
         if (sec_we) begin
            sec_cnt_ff[sec_addr] <= sec_cnt_in;
            sec_sub_ff[sec_addr] <= sec_sub_in;
         end
         if (min_we) begin
            min_cnt_ff[min_addr] <= min_cnt_in;
            min_sub_ff[min_addr] <= min_sub_in;
         end
         if (hour_we) begin
            hour_cnt_ff[hour_addr] <= hour_cnt_in;
            hour_sub_ff[hour_addr] <= hour_sub_in;
         end
      end
   end

   always_comb begin
      res_new = '0;
      if (cmd_head.kind == cstb_pkg::CMD_ERROR) begin
         res_new.index_error = 1'b1;
      end else if (cmd_head.kind == cstb_pkg::CMD_READ) begin
         unique case (cmd_head.bank)
            cstb_pkg::BANK_CENTI: res_new.count_value = centi_cnt_rd;
            cstb_pkg::BANK_DECI: begin
               res_new.count_value = deci_cnt_rd;
               res_new.sub_count   = 6'(deci_sub_rd);
            end
            cstb_pkg::BANK_SEC: begin
               res_new.count_value = sec_cnt_rd;
               res_new.sub_count   = 6'(sec_sub_rd);
            end
            cstb_pkg::BANK_MIN: begin
               res_new.count_value = min_cnt_rd;
               res_new.sub_count   = min_sub_rd;
            end
            cstb_pkg::BANK_HOUR: begin
               res_new.count_value = hour_cnt_rd;
               res_new.sub_count   = hour_sub_rd;
            end
            default: res_new = '0;
         endcase
      end
   end

   assign rsp_empty       = (rq_count_ff == 2'd0);
   assign rq_pop_take     = rsp_pop && !rsp_empty;
   assign rsp_count_value = rq_ff[rq_rd_ff].count_value;
   assign rsp_sub_count   = rq_ff[rq_rd_ff].sub_count;
   assign rsp_index_error = rq_ff[rq_rd_ff].index_error;

   always_comb begin
      rq_wr_in    = cmd_take ? !rq_wr_ff : rq_wr_ff;
      rq_rd_in    = rq_pop_take ? !rq_rd_ff : rq_rd_ff;
      rq_count_in = rq_count_ff + {1'b0, cmd_take} - {1'b0, rq_pop_take};
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         rq_ff[rq_wr_ff] <= res_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= cstb_pkg::BK_IDLE;
         walk_ff         <= '0;
         shared_centi_ff <= 4'd0;
         shared_deci_ff  <= 4'd0;
         shared_sec_ff   <= 6'd0;
         step_sec_ff     <= 1'b0;
         step_min_ff     <= 1'b0;
         step_hour_ff    <= 1'b0;
         rq_wr_ff        <= 1'b0;
         rq_rd_ff        <= 1'b0;
         rq_count_ff     <= 2'd0;
      end else begin
         state_ff        <= state_in;
         walk_ff         <= walk_in;
         shared_centi_ff <= shared_centi_in;
         shared_deci_ff  <= shared_deci_in;
         shared_sec_ff   <= shared_sec_in;
         step_sec_ff     <= step_sec_in;
         step_min_ff     <= step_min_in;
         step_hour_ff    <= step_hour_in;
         rq_wr_ff        <= rq_wr_in;
         rq_rd_ff        <= rq_rd_in;
         rq_count_ff     <= rq_count_in;
      end
   end

endmodule

/* rtl/cascaded_software_timer_bank.sv */
// ----------------------------------------------------------------------------
// Cascaded software timer bank
// Five banks of saturating elapsed-time timers driven by 10 ms tick requests.
// ----------------------------------------------------------------------------
//   channel    handshake         payload
//   request    req_push/req_full req_opcode, req_timer_class, req_timer_index
//   response   rsp_pop/rsp_empty rsp_count_value, rsp_sub_count, rsp_index_error
//
// A start, read or rejected request is executed as the back end takes it; a tick
// is dispatched, then walks all slots of the largest bank (8), updating one slot
// of each bank per cycle (sec, min, hour banks only when their prescaler steps).
// Each request passes a two-entry command queue and a two-entry response queue.
// Synchronous reset clears all timers and prescalers.
// A full response queue stalls the back end; requests queue until it frees.
// ----------------------------------------------------------------------------
module cascaded_software_timer_bank (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_opcode,
   input  logic [2:0] req_timer_class,
   input  logic [2:0] req_timer_index,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_count_value,
   output logic [5:0] rsp_sub_count,
   output logic       rsp_index_error
);

   logic              cmd_valid;
   logic              cmd_pop;
   cstb_pkg::cmd_type cmd_head;

   cstb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_timer_class (req_timer_class),
      .req_timer_index (req_timer_index),
      .cmd_valid       (cmd_valid),
      .cmd_head        (cmd_head),
      .cmd_pop         (cmd_pop)
   );

   cstb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_head        (cmd_head),
      .cmd_pop         (cmd_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_count_value (rsp_count_value),
      .rsp_sub_count   (rsp_sub_count),
      .rsp_index_error (rsp_index_error)
   );

endmodule
